[hdl/leb_pkg.sv]
// ============================================================================
// leb_pkg
// Shared types and constants for the LEB128 varint encoder.
// ============================================================================
package leb_pkg;

    localparam int POSITION_WIDTH = 32;
    localparam int VALUE_WIDTH    = 64;
    localparam int GROUP_BITS     = 7;
    // must be a power of two
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_WIDTH     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_U32 = 2'd0,
        OP_U64 = 2'd1,
        OP_S32 = 2'd2,
        OP_S64 = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [1:0]             opcode;
        logic [VALUE_WIDTH-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic        last;
        logic [31:0] position;
    } t_out_item;

    typedef struct packed {
        logic                   is_signed;
        logic [VALUE_WIDTH-1:0] value;
    } t_job;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } t_back_state;

endpackage

[hdl/leb_front.sv]
// ============================================================================
// leb_front
// Accepts input transactions, decodes the opcode and normalizes the value
// to a 64-bit job (narrow modes masked or sign-extended).
// ============================================================================
module leb_front import leb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_data,
    output logic     o_job_valid,
    input  logic     i_job_full,
    output t_job     o_job
);

    logic                   r_valid;
    t_job                   r_job;
    t_job                   n_job;
    logic                   narrow;
    logic                   sgn;
    logic [31:0]            upper;

    always_comb begin
        narrow = (i_data.opcode == OP_U32) || (i_data.opcode == OP_S32);
        sgn    = (i_data.opcode == OP_S32) || (i_data.opcode == OP_S64);
        upper  = (sgn && i_data.value[31]) ? '1 : '0;
        n_job.is_signed = sgn;
        n_job.value     = narrow ? {upper, i_data.value[31:0]} : i_data.value;
    end

    assign o_stall     = r_valid && i_job_full;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_job <= n_job;
        end
    end

endmodule

[hdl/leb_queue.sv]
// ============================================================================
// leb_queue
// Short job queue between front and back end.
// ============================================================================
module leb_queue import leb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job                  r_mem [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] r_wr_ptr;
    logic [QPTR_WIDTH-1:0] r_rd_ptr;
    logic [QCNT_WIDTH-1:0] r_count;
    logic                  push_ok;
    logic                  pop_ok;

    assign o_full  = (r_count == QCNT_WIDTH'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + QPTR_WIDTH'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + QPTR_WIDTH'(1);
            end
            unique case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + QCNT_WIDTH'(1);
                2'b01:   r_count <= r_count - QCNT_WIDTH'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

[hdl/leb_back.sv]
// ============================================================================
// leb_back
// Emits one LEB128 byte per cycle unless stalled, from the job at the queue
// head, with the stream position counter and the output register.
// ============================================================================
module leb_back import leb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_job_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    t_back_state               r_state;
    t_back_state               n_state;
    logic [VALUE_WIDTH-1:0]    r_val;
    logic                      r_signed;
    logic [POSITION_WIDTH-1:0] r_pos;
    logic                      r_out_valid;
    t_out_item                 r_out;

    logic                      advance;
    logic                      have_src;
    logic                      load;
    logic                      pop;
    logic                      src_signed;
    logic [VALUE_WIDTH-1:0]    src;
    logic [VALUE_WIDTH-1:0]    shifted;
    logic [6:0]                grp;
    logic                      fin;

    // byte datapath
    always_comb begin
        src_signed = (r_state == ST_EMIT) ? r_signed : i_job.is_signed;
        src        = (r_state == ST_EMIT) ? r_val : i_job.value;
        grp        = src[GROUP_BITS-1:0];
        shifted    = {{GROUP_BITS{src_signed && src[VALUE_WIDTH-1]}},
                      src[VALUE_WIDTH-1:GROUP_BITS]};
        if (src_signed) begin
            fin = ((shifted == '0) && !grp[6]) || ((&shifted) && grp[6]);
        end else begin
            fin = (shifted == '0);
        end
    end

    // control outputs
    always_comb begin
        advance  = !r_out_valid || !i_stall;
        have_src = (r_state == ST_EMIT) || i_job_valid;
        load     = advance && have_src;
        pop      = advance && (r_state == ST_IDLE) && i_job_valid;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (pop && !fin) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (load && fin) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (advance) begin
                r_out_valid <= have_src;
            end
            if (load) begin
                r_pos <= r_pos + POSITION_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_val          <= shifted;
            r_signed       <= src_signed;
            r_out.byte_out <= {!fin, grp};
            r_out.last     <= fin;
            r_out.position <= 32'(r_pos);
        end
    end

    assign o_job_pop = pop;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_pos == $past(r_pos) + POSITION_WIDTH'(1)))
        else $error("position counter did not advance by one per byte");

    a_cont_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.byte_out[7] == !r_out.last))
        else $error("continuation flag disagrees with last");

    a_emit_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && r_out_valid) |-> !r_out.last)
        else $error("encoding still in progress after a last byte");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (r_state == ST_IDLE) && i_job_valid)
        else $error("job taken while previous encoding in progress");

endmodule

[hdl/leb128_varint_encoder.sv]
// ============================================================================
// leb128_varint_encoder
// LEB128 encoder for unsigned/signed 32/64-bit integers.
// ============================================================================
// Usage:
//   Input channel (i_valid / o_stall / i_data) takes one transaction per
//   value: an opcode (unsigned 32, unsigned 64, signed 32, signed 64) and
//   a 64-bit value. Output channel (o_valid / i_stall / o_data) returns one
//   transaction per encoded byte, with the last flag and the stream byte
//   position, least significant group first.
//   The first byte reaches o_data through the front register that accepts
//   the input transaction, then the queue write, then the output register.
//   Throughput: the back end emits one byte per cycle while i_stall is low;
//   a value has 1..5 bytes in 32-bit modes and 1..10 in 64-bit modes.
//   The front end keeps accepting values while the back end works, until
//   the two-entry queue and the front register are full.
//   Reset (synchronous, active low) empties the pipeline and clears the
//   position counter to zero. When the receiver stalls, the current byte
//   holds on o_data and the encoding pauses; the stall backs up through the
//   queue to o_stall.
// ============================================================================
module leb128_varint_encoder import leb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    logic front_valid;
    t_job front_job;
    logic q_full;
    logic q_valid;
    t_job q_job;
    logic q_pop;

    leb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_job_valid (front_valid),
        .i_job_full  (q_full),
        .o_job       (front_job)
    );

    leb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    leb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

endmodule
